>>> design/sbt_pkg.sv
package sbt_pkg;

	localparam int WORD_W  = 32;
	localparam int SEL_W   = 5;
	localparam int TAG_W   = 27;
	localparam int CMD_W   = 2;
	localparam int COUNT_W = 5;

	localparam logic [CMD_W-1:0] CMD_TEST  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_done;
	} dp_stat_t;

endpackage

>>> design/sbt_req_if.sv
interface sbt_req_if;
	logic                       valid;
	logic                       ready;
	logic [sbt_pkg::CMD_W-1:0]  cmd;
	logic [sbt_pkg::WORD_W-1:0] bit_index;

	modport source (output valid, output cmd, output bit_index, input ready);
	modport sink   (input valid, input cmd, input bit_index, output ready);
endinterface

>>> design/sbt_rsp_if.sv
interface sbt_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        bit_value;
	logic                        status;
	logic [sbt_pkg::COUNT_W-1:0] entries_used;

	modport source (output valid, output bit_value, output status, output entries_used,
		input ready);
	modport sink   (input valid, input bit_value, input status, input entries_used,
		output ready);
endinterface

>>> design/sbt_ram.sv
module sbt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/sbt_ctrl.sv
module sbt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output sbt_pkg::ctrl_cmd_t cmd,
	input  sbt_pkg::dp_stat_t  stat
);
	import sbt_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_vld_q;
	logic   slot_free;

	assign slot_free = !out_vld_q || rsp_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.scan_done) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready  = 1'b0;
		cmd.load   = 1'b0;
		cmd.step   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			ST_SCAN: begin
				cmd.step = 1'b1;
			end
			ST_UPDATE: begin
				cmd.commit = slot_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_vld_q;

	// a new result never overwrites one still waiting
	a_commit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_vld_q || rsp_ready))
		else $error("result overwritten before taken");

	a_load_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_SCAN) && !req_ready)
		else $error("request accepted without scan");

endmodule

>>> design/sbt_dp.sv
module sbt_dp #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sbt_pkg::ctrl_cmd_t          cmd,
	output sbt_pkg::dp_stat_t           stat,
	input  logic [sbt_pkg::CMD_W-1:0]   req_cmd,
	input  logic [sbt_pkg::WORD_W-1:0]  req_bit_index,
	output logic                        bit_value,
	output logic                        status,
	output logic [sbt_pkg::COUNT_W-1:0] entries_used
);
	import sbt_pkg::*;

	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int RW = TAG_W + WORD_W;
	localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);

	logic [CMD_W-1:0]  cmd_q;
	logic [TAG_W-1:0]  tag_q;
	logic [SEL_W-1:0]  sel_q;
	logic [CW-1:0]     fill_q;
	logic [CW-1:0]     rd_ptr_q;
	logic              rd_vld_q;
	logic [AW-1:0]     rd_addr_q;
	logic              hit_q;
	logic [AW-1:0]     hit_pos_q;
	logic [WORD_W-1:0] hit_bits_q;
	logic              bit_value_q;
	logic              status_q;

	logic [RW-1:0]     rd_data;
	logic [RW-1:0]     wr_data;
	logic [AW-1:0]     wr_addr;
	logic              wr_en;
	logic              match;
	logic              issue;
	logic              is_wr;
	logic              full;
	logic [WORD_W-1:0] mask;
	logic [WORD_W-1:0] base;
	logic [WORD_W-1:0] new_bits;
	logic [CW+COUNT_W-1:0] fill_ext;

	assign match = rd_vld_q && (rd_data[RW-1:WORD_W] == tag_q);
	assign issue = cmd.step && (rd_ptr_q != fill_q) && !match;
	assign stat.scan_done = match || ((rd_ptr_q == fill_q) && !rd_vld_q);

	assign mask     = WORD_W'(1) << sel_q;
	assign base     = hit_q ? hit_bits_q : '0;
	assign new_bits = (cmd_q == CMD_SET) ? (base | mask) : (base & ~mask);
	assign is_wr    = (cmd_q == CMD_SET) || (cmd_q == CMD_CLEAR);
	assign full     = !hit_q && (fill_q == FULL_CNT);
	assign wr_en    = cmd.commit && is_wr && !full;
	assign wr_addr  = hit_q ? hit_pos_q : fill_q[AW-1:0];
	assign wr_data  = {tag_q, new_bits};

	sbt_ram #(
		.WIDTH (RW),
		.DEPTH (TABLE_ENTRIES),
		.AW    (AW)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (issue),
		.raddr (rd_ptr_q[AW-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= req_cmd;
			tag_q <= req_bit_index[WORD_W-1:SEL_W];
			sel_q <= req_bit_index[SEL_W-1:0];
		end
		if (issue) begin
			rd_addr_q <= rd_ptr_q[AW-1:0];
		end
		if (match) begin
			hit_pos_q  <= rd_addr_q;
			hit_bits_q <= rd_data[WORD_W-1:0];
		end
		if (cmd.commit) begin
			bit_value_q <= (cmd_q == CMD_TEST) && hit_q && |(hit_bits_q & mask);
			status_q    <= (is_wr && full) ? STATUS_FULL : STATUS_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			rd_ptr_q <= '0;
			rd_vld_q <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			if (cmd.load) begin
				rd_ptr_q <= '0;
				rd_vld_q <= 1'b0;
				hit_q    <= 1'b0;
			end else begin
				rd_vld_q <= issue;
				if (issue) begin
					rd_ptr_q <= rd_ptr_q + CW'(1);
				end
				if (match) begin
					hit_q <= 1'b1;
				end
			end
			if (wr_en && !hit_q) begin
				fill_q <= fill_q + CW'(1);
			end
		end
	end

	assign fill_ext     = {{COUNT_W{1'b0}}, fill_q};
	assign bit_value    = bit_value_q;
	assign status       = status_q;
	assign entries_used = fill_ext[COUNT_W-1:0];

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_CNT)
		else $error("fill count beyond capacity");

	a_hit_keeps_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && hit_q) |=> fill_q == $past(fill_q))
		else $error("fill count moved on an existing word");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_ptr_q <= fill_q)
		else $error("scan read beyond filled entries");

endmodule

>>> design/sparse_bitset_table.sv
// Sparse bit set held as a table of 32-bit words, each tagged with its word
// number (bit index >> 5).
// req channel: cmd (0 test, 1 set, 2 clear, 3 ignored) and bit_index.
// rsp channel: one response per request with bit_value (test only),
//   status (1 = table full, request ignored) and entries_used.
// A set or clear of an absent word takes the next free entry as a cleared
// word first; the table never shrinks.
// One request at a time. The tag search reads one entry per cycle from the
// table RAM, filled entries in order, and stops early on a hit; on an empty
// table it ends without a read. The next request can be taken in the cycle
// after the response is loaded.
// The response sits in an output register; req is taken again as soon as
// that register has been loaded, and a stalled rsp only holds the next
// request in its update step until the waiting response is taken.
// Reset empties the table at once (fill count to zero, no clearing pass)
// and drops any pending response.
module sparse_bitset_table #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	sbt_req_if.sink   req,
	sbt_rsp_if.source rsp
);
	import sbt_pkg::*;

	ctrl_cmd_t ctrl_cmd;
	dp_stat_t  dp_stat;

	sbt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (ctrl_cmd),
		.stat      (dp_stat)
	);

	sbt_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (ctrl_cmd),
		.stat          (dp_stat),
		.req_cmd       (req.cmd),
		.req_bit_index (req.bit_index),
		.bit_value     (rsp.bit_value),
		.status        (rsp.status),
		.entries_used  (rsp.entries_used)
	);

endmodule
